// ----- hdl/gql_pkg.sv -----
package gql_pkg;

    localparam int GLYPH_COUNT_DEF = 96;
    localparam int FIRST_CODE_DEF  = 32;
    localparam int QUEUE_DEPTH     = 2;

    localparam int ATLAS_W  = 13;
    localparam int COORD_W  = 16;
    localparam int TEX_W    = 17;
    localparam int ENTRY_W  = 64;
    localparam int IN_DATA_W  = 120;
    localparam int OUT_DATA_W = 88;

    localparam logic [ATLAS_W-1:0] ATLAS_WIDTH_RST  = 13'd1024;
    localparam logic [ATLAS_W-1:0] ATLAS_HEIGHT_RST = 13'd64;

    // 1.16 texture coordinate worked out to one extra bit, then rounded
    localparam logic [4:0]       DIV_STEPS = 5'd17;
    localparam logic [TEX_W-1:0] TEX_ONE   = 17'h10000;

    // per-vertex corner selection, bit k for vertex k
    localparam logic [5:0] VTX_RIGHT = 6'b011010;
    localparam logic [5:0] VTX_TOP   = 6'b110100;
    localparam logic [2:0] VTX_LAST  = 3'd5;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_START  = 2'd1,
        OP_LAYOUT = 2'd2
    } op_t;

    typedef enum logic {
        CFG_ATLAS_WIDTH  = 1'b0,
        CFG_ATLAS_HEIGHT = 1'b1
    } cfg_addr_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_EMIT
    } bk_state_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] xl;
        logic signed [COORD_W-1:0] yb;
        logic signed [COORD_W-1:0] z;
        logic [11:0]               col;
        logic [7:0]                w;
        logic [7:0]                h;
    } job_t;

endpackage

// ----- hdl/gql_ram.sv -----
module gql_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                      wdata,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/gql_fifo.sv -----
module gql_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);

    localparam int PTR_W = DEPTH > 1 ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign dout  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// ----- hdl/gql_front.sv -----
module gql_front #(
    parameter int GLYPH_COUNT = gql_pkg::GLYPH_COUNT_DEF,
    parameter int FIRST_CODE  = gql_pkg::FIRST_CODE_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [1:0]                     s_tuser,
    input  logic [gql_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic                           q_full,
    output logic                           q_push,
    output gql_pkg::job_t                  q_job
);

    import gql_pkg::*;

    localparam int IDX_W = GLYPH_COUNT > 1 ? $clog2(GLYPH_COUNT) : 1;

    // input word fields
    op_t                       in_op;
    logic [7:0]                in_code;
    logic [ENTRY_W-1:0]        in_entry;
    logic signed [COORD_W-1:0] in_sx, in_sy, in_sz;
    logic                      in_hit;
    logic [IDX_W-1:0]          in_idx;
    logic                      accept;

    assign in_op    = op_t'(s_tuser);
    assign in_code  = s_tdata[7:0];
    // entry: width, height, bearings, advances, column from the low bit up
    assign in_entry = s_tdata[71:8];
    assign in_sx    = s_tdata[87:72];
    assign in_sy    = s_tdata[103:88];
    assign in_sz    = s_tdata[119:104];
    assign in_hit   = (in_code >= 8'(FIRST_CODE)) &&
                      ({1'b0, in_code} < 9'(FIRST_CODE + GLYPH_COUNT));
    assign in_idx   = IDX_W'(in_code - 8'(FIRST_CODE));

    assign accept = s_tvalid && s_tready;

    logic             ram_we, ram_re;
    logic [ENTRY_W-1:0] ram_rdata;

    assign ram_we = accept && (in_op == OP_LOAD) && in_hit;
    assign ram_re = accept && (in_op == OP_LAYOUT) && in_hit;

    gql_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (GLYPH_COUNT)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (in_idx),
        .wdata (in_entry),
        .rdata (ram_rdata)
    );

    // second stage: table word arrives, pen is updated in word order
    logic                      stg_valid_reg, stg_valid_next;
    op_t                       stg_op_reg;
    logic                      stg_hit_reg;
    logic signed [COORD_W-1:0] stg_sx_reg, stg_sy_reg, stg_sz_reg;
    logic signed [COORD_W-1:0] pen_x_reg, pen_x_next;
    logic signed [COORD_W-1:0] pen_y_reg, pen_y_next;
    logic signed [COORD_W-1:0] pen_z_reg, pen_z_next;
    logic                      stg_go;

    logic [7:0]       g_w, g_h;
    logic signed [8:0] g_bl, g_bt, g_ax, g_ay;
    logic [11:0]      g_col;

    assign g_w   = ram_rdata[7:0];
    assign g_h   = ram_rdata[15:8];
    assign g_bl  = ram_rdata[24:16];
    assign g_bt  = ram_rdata[33:25];
    assign g_ax  = ram_rdata[42:34];
    assign g_ay  = ram_rdata[51:43];
    assign g_col = ram_rdata[63:52];

    assign stg_go   = stg_valid_reg && !q_full;
    assign s_tready = !stg_valid_reg || !q_full;

    always_comb begin
        stg_valid_next = stg_valid_reg;
        pen_x_next     = pen_x_reg;
        pen_y_next     = pen_y_reg;
        pen_z_next     = pen_z_reg;
        q_push         = 1'b0;
        if (accept) begin
            stg_valid_next = 1'b1;
        end else if (stg_go) begin
            stg_valid_next = 1'b0;
        end
        if (stg_go) begin
            case (stg_op_reg)
                OP_START: begin
                    pen_x_next = stg_sx_reg;
                    pen_y_next = stg_sy_reg;
                    pen_z_next = stg_sz_reg;
                end
                OP_LAYOUT: begin
                    if (stg_hit_reg) begin
                        pen_x_next = pen_x_reg + COORD_W'(g_ax);
                        pen_y_next = pen_y_reg + COORD_W'(g_ay);
                        q_push     = (g_w != '0) && (g_h != '0);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        q_job.xl  = pen_x_reg + COORD_W'(g_bl);
        q_job.yb  = pen_y_reg - COORD_W'(g_h) + COORD_W'(g_bt);
        q_job.z   = pen_z_reg;
        q_job.col = g_col;
        q_job.w   = g_w;
        q_job.h   = g_h;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_valid_reg <= 1'b0;
            pen_x_reg     <= '0;
            pen_y_reg     <= '0;
            pen_z_reg     <= '0;
        end else begin
            stg_valid_reg <= stg_valid_next;
            pen_x_reg     <= pen_x_next;
            pen_y_reg     <= pen_y_next;
            pen_z_reg     <= pen_z_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            stg_op_reg  <= in_op;
            stg_hit_reg <= in_hit;
            stg_sx_reg  <= in_sx;
            stg_sy_reg  <= in_sy;
            stg_sz_reg  <= in_sz;
        end
    end

endmodule

// ----- hdl/gql_div.sv -----
module gql_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [gql_pkg::ATLAS_W-1:0]   num,
    input  logic [gql_pkg::ATLAS_W-1:0]   den,
    output logic                          done,
    output logic [gql_pkg::TEX_W-1:0]     quot
);

    import gql_pkg::*;

    logic [4:0]         cnt_reg, cnt_next;
    logic [ATLAS_W-1:0] rem_reg, rem_next;
    logic [ATLAS_W-1:0] den_reg, den_next;
    logic [TEX_W-1:0]   acc_reg, acc_next;
    logic               sat_reg, sat_next;
    logic [ATLAS_W:0]   shifted;
    logic [TEX_W:0]     rounded;

    // restoring division, one quotient bit a cycle
    assign shifted = {rem_reg, 1'b0};

    always_comb begin
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        acc_next = acc_reg;
        sat_next = sat_reg;
        if (start) begin
            cnt_next = DIV_STEPS;
            rem_next = num;
            den_next = den;
            acc_next = '0;
            sat_next = (num >= den);
        end else if (cnt_reg != '0) begin
            cnt_next = cnt_reg - 1'b1;
            if (shifted >= {1'b0, den_reg}) begin
                rem_next = ATLAS_W'(shifted - {1'b0, den_reg});
                acc_next = {acc_reg[TEX_W-2:0], 1'b1};
            end else begin
                rem_next = ATLAS_W'(shifted);
                acc_next = {acc_reg[TEX_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        acc_reg <= acc_next;
        sat_reg <= sat_next;
    end

    // round half up from the extra bit; quotient of 1.0 or more clamps
    assign rounded = {1'b0, acc_reg} + 1'b1;
    assign done    = (cnt_reg == '0);
    assign quot    = sat_reg ? TEX_ONE : rounded[TEX_W:1];

endmodule

// ----- hdl/gql_back.sv -----
module gql_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [gql_pkg::ATLAS_W-1:0]    atlas_width,
    input  logic [gql_pkg::ATLAS_W-1:0]    atlas_height,
    input  logic                           q_empty,
    output logic                           q_pop,
    input  gql_pkg::job_t                  q_job,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [gql_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                           m_tlast
);

    import gql_pkg::*;

    bk_state_t state_reg, state_next;
    logic [2:0] vtx_reg, vtx_next;
    logic signed [COORD_W-1:0] xl_reg, xr_reg, yb_reg, yt_reg, z_reg;

    logic [ATLAS_W-1:0] den_u, den_v;
    logic               div_start;
    logic               u0_done, u1_done, v1_done;
    logic [TEX_W-1:0]   u0, u1, v1;
    logic               out_fire;

    // a zero atlas size counts as one
    assign den_u = (atlas_width  == '0) ? ATLAS_W'(1) : atlas_width;
    assign den_v = (atlas_height == '0) ? ATLAS_W'(1) : atlas_height;

    gql_div u_div_u0 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (ATLAS_W'(q_job.col)),
        .den     (den_u),
        .done    (u0_done),
        .quot    (u0)
    );

    gql_div u_div_u1 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (ATLAS_W'(q_job.col) + ATLAS_W'(q_job.w)),
        .den     (den_u),
        .done    (u1_done),
        .quot    (u1)
    );

    gql_div u_div_v1 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (ATLAS_W'(q_job.h)),
        .den     (den_v),
        .done    (v1_done),
        .quot    (v1)
    );

    assign out_fire = m_tvalid && m_tready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: begin
                if (!q_empty) begin
                    state_next = BK_DIV;
                end
            end
            BK_DIV: begin
                if (u0_done && u1_done && v1_done) begin
                    state_next = BK_EMIT;
                end
            end
            BK_EMIT: begin
                if (out_fire && (vtx_reg == VTX_LAST)) begin
                    state_next = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb begin
        q_pop     = 1'b0;
        div_start = 1'b0;
        m_tvalid  = 1'b0;
        case (state_reg)
            BK_IDLE: begin
                q_pop     = !q_empty;
                div_start = !q_empty;
            end
            BK_EMIT: begin
                m_tvalid = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        vtx_next = vtx_reg;
        if (q_pop) begin
            vtx_next = '0;
        end else if (out_fire) begin
            vtx_next = vtx_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
            vtx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            vtx_reg   <= vtx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            xl_reg <= q_job.xl;
            xr_reg <= q_job.xl + COORD_W'(q_job.w);
            yb_reg <= q_job.yb;
            yt_reg <= q_job.yb + COORD_W'(q_job.h);
            z_reg  <= q_job.z;
        end
    end

    // u follows the x corner, v follows the y corner (top edge has v = 0)
    logic is_right, is_top;

    assign is_right = VTX_RIGHT[vtx_reg];
    assign is_top   = VTX_TOP[vtx_reg];

    always_comb begin
        m_tdata        = '0;
        m_tdata[15:0]  = is_right ? xr_reg : xl_reg;
        m_tdata[31:16] = is_top ? yt_reg : yb_reg;
        m_tdata[47:32] = z_reg;
        m_tdata[64:48] = is_right ? u1 : u0;
        m_tdata[81:65] = is_top ? '0 : v1;
    end

    assign m_tlast = (vtx_reg == VTX_LAST);

endmodule

// ----- hdl/glyph_quad_layout.sv -----
// Glyph quad layout. Words on the slave side carry an opcode in tuser: load a
// glyph table entry, start a string (pen x, y and depth), or lay out one
// character. Load and start words, and characters outside the table, end in
// the front stage. A character whose glyph has a non-zero size turns into six
// vertex words (two triangles, tlast on the sixth). In the back end a job is
// picked off the queue, the bit-serial texture coordinate dividers run and are
// seen to finish, then the vertices go out as the master side takes them. A
// two-entry job queue lets the front keep taking words while vertices drain.
// Texture coordinates are unsigned 1.16 fixed point, rounded to nearest and
// clamped at 1.0. Laying out a code whose entry was never loaded gives
// undefined vertices.
module glyph_quad_layout #(
    parameter int GLYPH_COUNT = gql_pkg::GLYPH_COUNT_DEF,
    parameter int FIRST_CODE  = gql_pkg::FIRST_CODE_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic                           cfg_addr,
    input  logic [gql_pkg::ATLAS_W-1:0]    cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // opcode
    input  logic [1:0]                     s_tuser,
    // char_code, glyph_width, glyph_height, bearing_left, bearing_top,
    // advance_x, advance_y, atlas_column, start_x, start_y, start_z
    input  logic [gql_pkg::IN_DATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // vertex_x, vertex_y, vertex_z, tex_u, tex_v, zero pad
    output logic [gql_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                           m_tlast
);

    import gql_pkg::*;

    logic [ATLAS_W-1:0] atlas_width_reg, atlas_width_next;
    logic [ATLAS_W-1:0] atlas_height_reg, atlas_height_next;

    always_comb begin
        atlas_width_next  = atlas_width_reg;
        atlas_height_next = atlas_height_reg;
        if (cfg_wr_en) begin
            case (cfg_addr_t'(cfg_addr))
                CFG_ATLAS_WIDTH:  atlas_width_next  = cfg_wdata;
                CFG_ATLAS_HEIGHT: atlas_height_next = cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            atlas_width_reg  <= ATLAS_WIDTH_RST;
            atlas_height_reg <= ATLAS_HEIGHT_RST;
        end else begin
            atlas_width_reg  <= atlas_width_next;
            atlas_height_reg <= atlas_height_next;
        end
    end

    logic q_push, q_pop, q_full, q_empty;
    job_t q_in, q_out;

    gql_front #(
        .GLYPH_COUNT (GLYPH_COUNT),
        .FIRST_CODE  (FIRST_CODE)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_job    (q_in)
    );

    gql_fifo #(
        .WIDTH ($bits(job_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     (q_in),
        .full    (q_full),
        .pop     (q_pop),
        .dout    (q_out),
        .empty   (q_empty)
    );

    gql_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .atlas_width  (atlas_width_reg),
        .atlas_height (atlas_height_reg),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .q_job        (q_out),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast)
    );

endmodule
